// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files of the quadrature decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while the block is out of reset.
`define QD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define QD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/qdec_pkg.sv -----
package qdec_pkg;

  // Channel count by default, and the number of channels that have pins.
  localparam int unsigned CHANNELS_DEF = 4;
  localparam int unsigned PIN_CHANNELS = 4;

  // Field widths.
  localparam int unsigned HIST_W  = 4;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // History patterns of one forward step; a backward step reads them swapped.
  localparam logic [HIST_W-1:0] PAT_FWD_A = 4'b1001;
  localparam logic [HIST_W-1:0] PAT_FWD_B = 4'b1100;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } opcode_e;

  // Register index, taken from paddr[2].
  typedef enum logic {
    REG_ENABLE_MASK = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_e;

  // Per-lane control from the top level.
  typedef struct packed {
    logic enable;
    logic clear;
    logic sample;
    logic read_clear;
  } lane_ctrl_t;

  // Occupancy of the result buffer.
  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } merge_stat_t;

endpackage

// ----- rtl/core/qdec_in_if.sv -----
interface qdec_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [qdec_pkg::PIN_CHANNELS-1:0] a_levels;
  logic [qdec_pkg::PIN_CHANNELS-1:0] b_levels;
  logic [qdec_pkg::CHAN_W-1:0]   read_channel;

  modport source (output valid, opcode, a_levels, b_levels, read_channel, input ready);
  modport sink   (input valid, opcode, a_levels, b_levels, read_channel, output ready);
endinterface

// ----- rtl/core/qdec_out_if.sv -----
interface qdec_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [qdec_pkg::COUNT_W-1:0] step_count;
  logic [qdec_pkg::CHAN_W-1:0]        echo_channel;

  modport source (output valid, step_count, echo_channel, input ready);
  modport sink   (input valid, step_count, echo_channel, output ready);
endinterface

// ----- rtl/core/qdec_lane.sv -----
module qdec_lane (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  qdec_pkg::lane_ctrl_t         ctrl_i,
  input  logic                         a_i,
  input  logic                         b_i,
  output logic [qdec_pkg::COUNT_W-1:0] count_o
);

  logic [qdec_pkg::HIST_W-1:0]  ha_q, ha_d, hb_q, hb_d;
  logic [qdec_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic [qdec_pkg::HIST_W-1:0]  ha_sh, hb_sh;
  logic                         moved, fwd, bwd;

  // Shift the new levels in and look for a full step in the histories.
  always_comb begin
    ha_sh = {ha_q[qdec_pkg::HIST_W-2:0], a_i};
    hb_sh = {hb_q[qdec_pkg::HIST_W-2:0], b_i};
    moved = (a_i != ha_q[0]) || (b_i != hb_q[0]);
    fwd   = (ha_sh == qdec_pkg::PAT_FWD_A) && (hb_sh == qdec_pkg::PAT_FWD_B);
    bwd   = (ha_sh == qdec_pkg::PAT_FWD_B) && (hb_sh == qdec_pkg::PAT_FWD_A);
  end

  // Next state: a register write clears, otherwise a sample or a read acts in an enabled lane.
  always_comb begin
    ha_d  = ha_q;
    hb_d  = hb_q;
    cnt_d = cnt_q;
    if (ctrl_i.clear) begin
      ha_d  = '0;
      hb_d  = '0;
      cnt_d = '0;
    end else if (ctrl_i.enable) begin
      if (ctrl_i.sample && moved) begin
        ha_d = ha_sh;
        hb_d = hb_sh;
        if (fwd) begin
          cnt_d = cnt_q + qdec_pkg::COUNT_W'(1);
        end else if (bwd) begin
          cnt_d = cnt_q - qdec_pkg::COUNT_W'(1);
        end
      end
      if (ctrl_i.read_clear) begin
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ha_q  <= '0;
      hb_q  <= '0;
      cnt_q <= '0;
    end else begin
      ha_q  <= ha_d;
      hb_q  <= hb_d;
      cnt_q <= cnt_d;
    end
  end

  assign count_o = cnt_q;

endmodule

// ----- rtl/core/qdec_merge.sv -----
module qdec_merge #(
  parameter int unsigned LANES = qdec_pkg::PIN_CHANNELS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         read_i,
  input  logic [qdec_pkg::CHAN_W-1:0]  read_channel_i,
  input  logic [qdec_pkg::PIN_CHANNELS-1:0] enable_i,
  input  logic [qdec_pkg::COUNT_W-1:0] counts_i [LANES],
  output logic [LANES-1:0]             read_clear_o,
  output logic                         in_ready_o,
  output qdec_pkg::merge_stat_t        stat_o,
  qdec_out_if.source                   result
);

  logic [qdec_pkg::COUNT_W-1:0] sel_count;
  logic                         out_valid_q, out_valid_d;
  logic                         skid_valid_q, skid_valid_d;
  logic [qdec_pkg::COUNT_W-1:0] out_count_q, skid_count_q;
  logic [qdec_pkg::CHAN_W-1:0]  out_chan_q, skid_chan_q;
  logic                         out_free;
  logic                         load_out, load_skid, skid_to_out;

  // Pick the count of the read channel; disabled or missing channels give zero.
  always_comb begin
    sel_count    = '0;
    read_clear_o = '0;
    for (int i = 0; i < int'(LANES); i++) begin
      if (read_channel_i == qdec_pkg::CHAN_W'(i) && enable_i[i]) begin
        sel_count       = counts_i[i];
        read_clear_o[i] = read_i;
      end
    end
  end

  // Output register with a skid stage behind it.
  always_comb begin
    out_free     = !out_valid_q || result.ready;
    skid_to_out  = out_free && skid_valid_q;
    load_out     = out_free && !skid_valid_q && read_i;
    load_skid    = !out_free && read_i;
    out_valid_d  = out_free ? (skid_valid_q || read_i) : out_valid_q;
    skid_valid_d = skid_to_out ? 1'b0 : (skid_valid_q || load_skid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_to_out) begin
      out_count_q <= skid_count_q;
      out_chan_q  <= skid_chan_q;
    end else if (load_out) begin
      out_count_q <= sel_count;
      out_chan_q  <= read_channel_i;
    end
    if (load_skid) begin
      skid_count_q <= sel_count;
      skid_chan_q  <= read_channel_i;
    end
  end

  assign in_ready_o          = !skid_valid_q;
  assign stat_o.out_valid    = out_valid_q;
  assign stat_o.skid_valid   = skid_valid_q;
  assign result.valid        = out_valid_q;
  assign result.step_count   = out_count_q;
  assign result.echo_channel = out_chan_q;

endmodule

// ----- rtl/core/multi_quadrature_decoder_unit.sv -----
// Channel   Role    Transfer carries
// sample_i  sink    opcode, a_levels, b_levels, read_channel
// result_o  source  step_count, echo_channel (one per read, none per sample)
// APB       slave   enable_mask at byte address 0
//
// At the edge that accepts an item, the enabled lanes update their histories
// and counts, and a read result is loaded into the result or skid register.
// A result register and a skid stage let one more read in while a result is
// stalled; the input stalls only when both are full.
// Reset clears the enable mask, all histories and all counts at once.
`include "assert_macros.svh"

module multi_quadrature_decoder_unit #(
  parameter int unsigned CHANNELS = qdec_pkg::CHANNELS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qdec_in_if.sink                       sample_i,
  qdec_out_if.source                    result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qdec_pkg::PADDR_W-1:0]  paddr,
  input  logic [qdec_pkg::PDATA_W-1:0]  pwdata,
  output logic [qdec_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Only channels with pins get a lane.
  localparam int unsigned LANES = (CHANNELS < qdec_pkg::PIN_CHANNELS) ?
                                  CHANNELS : qdec_pkg::PIN_CHANNELS;

  logic [qdec_pkg::PIN_CHANNELS-1:0] enable_q;
  logic                              cfg_wr;
  logic                              in_xfer, do_sample, do_read;
  logic [qdec_pkg::COUNT_W-1:0]      lane_count [LANES];
  logic [LANES-1:0]                  read_clear;
  qdec_pkg::lane_ctrl_t              lane_ctrl [LANES];
  qdec_pkg::merge_stat_t             mstat;
  logic                              in_ready;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[2] == qdec_pkg::REG_ENABLE_MASK);

  always_comb begin
    prdata = '0;
    if (paddr[2] == qdec_pkg::REG_ENABLE_MASK) begin
      prdata = qdec_pkg::PDATA_W'(enable_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_wr) begin
      enable_q <= pwdata[qdec_pkg::PIN_CHANNELS-1:0];
    end
  end

  // Input transfer decode.
  assign sample_i.ready = in_ready;
  assign in_xfer   = sample_i.valid && in_ready;
  assign do_sample = in_xfer && (sample_i.opcode == qdec_pkg::OP_SAMPLE);
  assign do_read   = in_xfer && (sample_i.opcode == qdec_pkg::OP_READ);

  // One decoder lane per channel that has pins.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    always_comb begin
      lane_ctrl[g].enable     = enable_q[g];
      lane_ctrl[g].clear      = cfg_wr && pwdata[g];
      lane_ctrl[g].sample     = do_sample;
      lane_ctrl[g].read_clear = read_clear[g];
    end

    qdec_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl[g]),
      .a_i     (sample_i.a_levels[g]),
      .b_i     (sample_i.b_levels[g]),
      .count_o (lane_count[g])
    );
  end

  // Read selection and result buffering.
  qdec_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .read_i         (do_read),
    .read_channel_i (sample_i.read_channel),
    .enable_i       (enable_q),
    .counts_i       (lane_count),
    .read_clear_o   (read_clear),
    .in_ready_o     (in_ready),
    .stat_o         (mstat),
    .result         (result_o)
  );

  // Checks on the result buffer and on read-and-clear.
  `QD_ASSERT(a_skid_needs_out, mstat.skid_valid |-> mstat.out_valid, "skid full, output empty")
  `QD_ASSERT(a_sample_no_result, do_sample && !mstat.out_valid |=> !mstat.out_valid, "sample made a result")
  `QD_ASSERT(a_ready_skid, in_ready != mstat.skid_valid, "ready out of step with skid")
  for (genvar k = 0; k < LANES; k++) begin : g_chk
    `QD_ASSERT(a_read_clears, read_clear[k] |=> lane_count[k] == '0, "read did not clear count")
  end

endmodule

// ----- dv/tb_multi_quadrature_decoder_unit.sv -----
module tb_multi_quadrature_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import qdec_pkg::*;

  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DIR_ROWS      = 27;

  // One item on the sample channel, with an optional hand-typed count for reads.
  typedef struct packed {
    opcode_e                   op;
    logic [PIN_CHANNELS-1:0]   a_lv;
    logic [PIN_CHANNELS-1:0]   b_lv;
    logic [CHAN_W-1:0]         ch;
    logic                      fixed;
    logic signed [COUNT_W-1:0] fixed_count;
  } stim_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] step_count;
    logic [CHAN_W-1:0]         echo_channel;
  } reading_t;

  typedef enum logic {
    ROW_ITEM  = 1'b0,
    ROW_SETUP = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    reg_idx_e                  reg_sel;
    logic [PIN_CHANNELS-1:0]   cfg_val;
    opcode_e                   op;
    logic [PIN_CHANNELS-1:0]   a_lv;
    logic [PIN_CHANNELS-1:0]   b_lv;
    logic [CHAN_W-1:0]         ch;
    logic                      fixed;
    logic signed [COUNT_W-1:0] fixed_count;
  } dir_row_t;

  // Directed opening: disabled reads, one forward and one backward step on
  // every channel, a write to the unused address, partial enables and reads
  // of channels without pins.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h0, 1'b1, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'hf, 1'b1, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'hf, 4'hf, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'hf, 4'hf, 4'h3, 1'b1, 8'sd0},
    '{ROW_SETUP, REG_ENABLE_MASK, 4'hf, OP_SAMPLE, 4'h0, 4'h0, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'hf, 4'hf, 4'h5, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'h0, 4'hf, 4'ha, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'h0, 4'h0, 4'hc, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'hf, 4'h0, 4'h3, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'hf, 4'h0, 4'hf, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'hf, 4'hf, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'hf, 4'h0, 4'h9, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'h0, 4'h0, 4'h6, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'h0, 4'hf, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h1, 1'b0, 8'sd0},
    '{ROW_SETUP, REG_NONE,        4'h0, OP_SAMPLE, 4'h0, 4'h0, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h2, 1'b0, 8'sd0},
    '{ROW_SETUP, REG_ENABLE_MASK, 4'h5, OP_SAMPLE, 4'h0, 4'h0, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h1, 1'b1, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h4, 1'b1, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_SAMPLE, 4'hf, 4'hf, 4'hf, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h2, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'hf, 1'b1, 8'sd0},
    '{ROW_SETUP, REG_ENABLE_MASK, 4'hf, OP_SAMPLE, 4'h0, 4'h0, 4'h0, 1'b0, 8'sd0},
    '{ROW_ITEM,  REG_ENABLE_MASK, 4'h0, OP_READ,   4'h0, 4'h0, 4'h3, 1'b1, 8'sd0}
  };

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Side band that travels with the item on the sample channel.
  logic                      hold_fixed;
  logic signed [COUNT_W-1:0] hold_fixed_count;

  qdec_in_if  smp_if ();
  qdec_out_if res_if ();

  multi_quadrature_decoder_unit u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (smp_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Predicted state of the decoder.
  logic [PIN_CHANNELS-1:0]   live_mask;
  logic [HIST_W-1:0]         a_hist     [CHANNELS_DEF];
  logic [HIST_W-1:0]         b_hist     [CHANNELS_DEF];
  logic signed [COUNT_W-1:0] step_tally [CHANNELS_DEF];
  reading_t                  reading_q  [$];

  // Encoder positions of the stimulus, one quarter cycle per step.
  logic [1:0]                enc_pos    [PIN_CHANNELS];
  logic [PIN_CHANNELS-1:0]   enc_fwd;

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left  = 0;
  int unsigned gap_pct;
  int unsigned stall_pct;
  logic        calm;

  // Enabling a channel clears its histories and its count.
  function automatic void load_mask(input logic [PIN_CHANNELS-1:0] m);
    live_mask = m;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      if (c < PIN_CHANNELS && m[c]) begin
        a_hist[c]     = '0;
        b_hist[c]     = '0;
        step_tally[c] = '0;
      end
    end
  endfunction

  // Shift new levels into every enabled channel whose levels moved, then
  // count a full forward or backward quadrature cycle.
  function automatic void track_levels(input logic [PIN_CHANNELS-1:0] a_lv,
                                       input logic [PIN_CHANNELS-1:0] b_lv);
    logic [HIST_W-1:0] ha;
    logic [HIST_W-1:0] hb;
    for (int c = 0; c < CHANNELS_DEF; c++) begin
      if (c < PIN_CHANNELS && live_mask[c] &&
          (a_hist[c][0] != a_lv[c] || b_hist[c][0] != b_lv[c])) begin
        ha = {a_hist[c][HIST_W-2:0], a_lv[c]};
        hb = {b_hist[c][HIST_W-2:0], b_lv[c]};
        a_hist[c] = ha;
        b_hist[c] = hb;
        if (ha == PAT_FWD_A && hb == PAT_FWD_B) begin
          step_tally[c] = step_tally[c] + 8'sd1;
        end
        if (ha == PAT_FWD_B && hb == PAT_FWD_A) begin
          step_tally[c] = step_tally[c] - 8'sd1;
        end
      end
    end
  endfunction

  // A read hands out the count and clears it; anything else reads zero.
  function automatic logic signed [COUNT_W-1:0] take_count(input logic [CHAN_W-1:0] ch);
    logic signed [COUNT_W-1:0] cnt;
    cnt = '0;
    if (ch < CHANNELS_DEF && ch < PIN_CHANNELS && live_mask[ch]) begin
      cnt            = step_tally[ch];
      step_tally[ch] = '0;
    end
    return cnt;
  endfunction

  // Move each encoder by a quarter cycle (with wander, sometimes back or not at all) and return the pin levels.
  function automatic void walk_encoders(input logic [PIN_CHANNELS-1:0] fwd,
                                        input logic wander,
                                        output logic [PIN_CHANNELS-1:0] a_lv,
                                        output logic [PIN_CHANNELS-1:0] b_lv);
    int unsigned roll;
    for (int c = 0; c < PIN_CHANNELS; c++) begin
      roll = wander ? $urandom_range(0, 99) : 99;
      if (roll >= 40) begin
        enc_pos[c] = fwd[c] ? enc_pos[c] + 2'd1 : enc_pos[c] - 2'd1;
      end else if (roll >= 20) begin
        enc_pos[c] = fwd[c] ? enc_pos[c] - 2'd1 : enc_pos[c] + 2'd1;
      end
      a_lv[c] = (enc_pos[c] == 2'd0) || (enc_pos[c] == 2'd3);
      b_lv[c] = (enc_pos[c] == 2'd0) || (enc_pos[c] == 2'd1);
    end
  endfunction

  // Checks results against the oldest prediction and predicts each transfer.
  always @(posedge clk_i) begin : result_check
    reading_t want;
    if (rst_ni) begin
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        if (reading_q.size() == 0) begin
          $error("unexpected result: step_count %0d, echo_channel %0d",
                 res_if.step_count, res_if.echo_channel);
          fail_count++;
        end else begin
          want = reading_q.pop_front();
          if (res_if.step_count !== want.step_count) begin
            $error("step_count mismatch: expected %0d, got %0d",
                   want.step_count, res_if.step_count);
            fail_count++;
          end
          if (res_if.echo_channel !== want.echo_channel) begin
            $error("echo_channel mismatch: expected %0d, got %0d",
                   want.echo_channel, res_if.echo_channel);
            fail_count++;
          end
        end
      end
      if (smp_if.valid === 1'b1 && smp_if.ready === 1'b1) begin
        if (smp_if.opcode == OP_SAMPLE) begin
          track_levels(smp_if.a_levels, smp_if.b_levels);
        end else begin
          want.echo_channel = smp_if.read_channel;
          want.step_count   = take_count(smp_if.read_channel);
          if (hold_fixed) begin
            want.step_count = hold_fixed_count;
          end
          reading_q.push_back(want);
        end
      end
      if (psel && penable && pwrite && pready === 1'b1 &&
          reg_idx_e'(paddr[2]) == REG_ENABLE_MASK) begin
        load_mask(pwdata[PIN_CHANNELS-1:0]);
      end
    end
  end

  // Result channel back-pressure in random bursts.
  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left   <= 0;
      res_if.ready <= 1'b1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      stall_left   <= $urandom_range(1, 19);
      res_if.ready <= 1'b0;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one item, after an occasional gap, and wait for its transfer.
  task automatic send_item(input stim_t it);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    smp_if.valid        <= 1'b1;
    smp_if.opcode       <= it.op;
    smp_if.a_levels     <= it.a_lv;
    smp_if.b_levels     <= it.b_lv;
    smp_if.read_channel <= it.ch;
    hold_fixed          <= it.fixed;
    hold_fixed_count    <= it.fixed_count;
    do @(posedge clk_i); while (smp_if.ready !== 1'b1);
  endtask

  // Stop sending and wait for every outstanding result, plus a short margin.
  task automatic settle();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (reading_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup and access phase of one register transfer; psel is left high.
  task automatic cfg_access(input logic wr, input reg_idx_e idx,
                            input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
  endtask

  // Read back the enable mask and release the bus.
  task automatic check_mask(input logic [PIN_CHANNELS-1:0] m);
    logic [PDATA_W-1:0] rd;
    cfg_access(1'b0, REG_ENABLE_MASK, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[PIN_CHANNELS-1:0] !== m) begin
      $error("enable_mask mismatch: expected %0h, got %0h", m, rd[PIN_CHANNELS-1:0]);
      fail_count++;
    end
  endtask

  // The mask read back is the written value, or the old one for other addresses.
  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] rd;
    settle();
    cfg_access(1'b1, idx, data, rd);
    check_mask((idx == REG_ENABLE_MASK) ? data[PIN_CHANNELS-1:0] : live_mask);
  endtask

  // Mostly encoder walks with random content, some reads and some pin noise.
  task automatic run_phase(input logic [PIN_CHANNELS-1:0] m, input int unsigned n_items);
    stim_t       it;
    int unsigned roll;
    write_reg(REG_ENABLE_MASK, {{(PDATA_W-PIN_CHANNELS){1'b0}}, m});
    gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 15;
    stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
    enc_fwd   = PIN_CHANNELS'($urandom);
    for (int k = 0; k < n_items; k++) begin
      it      = '0;
      it.ch   = CHAN_W'($urandom);
      roll    = $urandom_range(0, 99);
      if (roll < 25) begin
        it.op   = OP_READ;
        it.a_lv = PIN_CHANNELS'($urandom);
        it.b_lv = PIN_CHANNELS'($urandom);
        if ($urandom_range(0, 4) != 0) begin
          it.ch = CHAN_W'($urandom_range(0, PIN_CHANNELS - 1));
        end
      end else if (roll < 33) begin
        it.a_lv = PIN_CHANNELS'($urandom);
        it.b_lv = PIN_CHANNELS'($urandom);
      end else begin
        walk_encoders(enc_fwd, 1'b1, it.a_lv, it.b_lv);
      end
      send_item(it);
    end
  endtask

  initial begin
    stim_t it;
    calm                = 1'b0;
    gap_pct             = 10;
    stall_pct           = 10;
    smp_if.valid        = 1'b0;
    smp_if.opcode       = OP_SAMPLE;
    smp_if.a_levels     = '0;
    smp_if.b_levels     = '0;
    smp_if.read_channel = '0;
    res_if.ready        = 1'b1;
    hold_fixed          = 1'b0;
    hold_fixed_count    = '0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    enc_fwd             = '0;
    load_mask('0);
    for (int c = 0; c < PIN_CHANNELS; c++) begin
      enc_pos[c] = 2'd2;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_mask('0);

    // Directed rows.
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_SETUP) begin
        write_reg(dir_rows[r].reg_sel,
                  {{(PDATA_W-PIN_CHANNELS){1'b0}}, dir_rows[r].cfg_val});
      end else begin
        it.op          = dir_rows[r].op;
        it.a_lv        = dir_rows[r].a_lv;
        it.b_lv        = dir_rows[r].b_lv;
        it.ch          = dir_rows[r].ch;
        it.fixed       = dir_rows[r].fixed;
        it.fixed_count = dir_rows[r].fixed_count;
        send_item(it);
      end
    end

    // Random phases over a spread of enable masks, both extremes included.
    run_phase({PIN_CHANNELS{1'b1}}, 110);
    run_phase('0, 60);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        write_reg(REG_NONE, PDATA_W'($urandom));
      end
      run_phase(PIN_CHANNELS'($urandom_range(1, (1 << PIN_CHANNELS) - 2)), 110);
    end

    // Long unbroken walks so the counts reach both ends and wrap round.
    write_reg(REG_ENABLE_MASK, {{(PDATA_W-PIN_CHANNELS){1'b0}}, {PIN_CHANNELS{1'b1}}});
    gap_pct   = 10;
    stall_pct = 10;
    for (int c = 0; c < PIN_CHANNELS; c++) begin
      enc_pos[c] = 2'd2;
    end
    for (int n = 1; n <= 520; n++) begin
      it    = '0;
      it.ch = CHAN_W'($urandom);
      walk_encoders(4'b1101, 1'b0, it.a_lv, it.b_lv);
      send_item(it);
      if (n == 509 || n == 513) begin
        it             = '0;
        it.op          = OP_READ;
        it.ch          = (n == 509) ? 4'd3 : 4'd1;
        it.fixed       = 1'b1;
        it.fixed_count = (n == 509) ? 8'sd127 : -8'sd128;
        send_item(it);
      end
    end
    for (int c = 0; c < PIN_CHANNELS; c++) begin
      it    = '0;
      it.op = OP_READ;
      it.ch = CHAN_W'(c);
      send_item(it);
    end

    // Final stretch at full rate on both sides.
    calm = 1'b1;
    run_phase({PIN_CHANNELS{1'b1}}, 100);
    settle();

    if (fail_count == 0 && reading_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
